[hdl/macd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_pkg: shared types for the MACD filter
// Sequencer states, average selector and CSR index codes, reset periods.
// ----------------------------------------------------------------------------
package macd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_ROUND,
      ST_DIV,
      ST_STORE,
      ST_DIFF,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      AVG_FAST,
      AVG_SLOW,
      AVG_SIGNAL
   } avg_sel_type;

   typedef enum logic [1:0] {
      CSR_SHORT_PERIOD,
      CSR_LONG_PERIOD,
      CSR_SIGNAL_PERIOD,
      CSR_UNUSED
   } csr_index_type;

   localparam logic [7:0] SHORT_PERIOD_RESET  = 8'd12;
   localparam logic [7:0] LONG_PERIOD_RESET   = 8'd26;
   localparam logic [7:0] SIGNAL_PERIOD_RESET = 8'd9;

endpackage

[hdl/macd_indicator_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_indicator_filter: MACD difference, signal and oscillator lines
// Three exponential averages share one bit-serial multiplier and one
// bit-serial rounding divider, worked through by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | contents
//  req_     | in        | tvalid/tready       | close_price (tdata), restart (tuser)
//  rsp_     | out       | tvalid/tready       | dif, signal, osc (tdata), ready (tuser)
//  csr_     | in        | wr_en, no wait      | short, long, signal periods
//
// Sequence: per average, SETUP then STORE while still warming up; SETUP,
//   ROUND, DIV, STORE for the seed; SETUP, MUL, ROUND, DIV, STORE for the
//   recurrence (NS = 57, PB = 8 at defaults); the divider gives one bit per cycle.
// Reset: synchronous; periods return to 12/26/9, all averages, sums and
//   the sample index clear. No clearing pass.
// Stalls: the next request is taken while a result waits on rsp_; the
//   sequencer holds in its last state until the result register is free.
// ----------------------------------------------------------------------------
module macd_indicator_filter
   import macd_pkg::*;
#(
   parameter int PRICE_BITS = 32,
   parameter int PERIOD_MAX = 255
) (
   input  logic clock,
   input  logic reset,
   // request: [PRICE_BITS-1:0] close_price, rest zero
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((PRICE_BITS+7)/8)*8-1:0] req_tdata,
   // request: [0] restart
   input  logic                            req_tuser,
   // response: dif_value, signal_value, osc_value (PRICE_BITS+1 each), pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((3*(PRICE_BITS+1)+7)/8)*8-1:0] rsp_tdata,
   // response: [0] ready_res
   output logic                                  rsp_tuser,
   // configuration writes
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int P     = PRICE_BITS;
   localparam int G     = (PRICE_BITS > 36) ? (51 - PRICE_BITS) : 15;  // guard bits
   localparam int PB    = $clog2(PERIOD_MAX + 1);
   localparam int IW    = $clog2(PERIOD_MAX + 2);
   localparam int AW    = P + G + 1;        // average, signed, guard precision
   localparam int SW    = P + PB;           // price seed sum, unsigned
   localparam int GW    = P + 1 + PB;       // signal seed sum, signed
   localparam int NS    = P + G + PB + 2;   // numerator / dividend
   localparam int CW    = $clog2(NS + 1);
   localparam int OW    = 3 * (P + 1);
   localparam int OUT_DW = ((OW + 7) / 8) * 8;
   localparam logic [IW-1:0] IDX_SAT = IW'(PERIOD_MAX + 1);

   // registers
   state_type              state_ff, state_in;
   avg_sel_type            sel_ff, sel_in;
   logic [7:0]             short_ff, short_in, long_ff, long_in, sigp_ff, sigp_in;
   logic [IW-1:0]          sample_index_ff, sample_index_in, idx_ff, idx_in;
   logic signed [AW-1:0]   fast_avg_ff, fast_avg_in, slow_avg_ff, slow_avg_in;
   logic signed [AW-1:0]   sig_avg_ff, sig_avg_in;
   logic [SW-1:0]          fast_sum_ff, fast_sum_in, slow_sum_ff, slow_sum_in;
   logic signed [GW-1:0]   sig_sum_ff, sig_sum_in;
   logic [P-1:0]           price_ff, price_in;
   logic signed [P:0]      x_ff, x_in, dif_ff, dif_in;
   logic signed [NS-1:0]   num_ff, num_in, mcand_ff, mcand_in;
   logic [PB-1:0]          mult_ff, mult_in;
   logic [PB:0]            den_ff, den_in;
   logic [PB+1:0]          rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   neg_ff, neg_in, skip_ff, skip_in;
   logic signed [AW-1:0]   rf_ff, rf_in, rs_ff, rs_in;  // rs holds signal result late
   logic                   rsp_valid_ff, rsp_valid_in, rsp_ready_ff, rsp_ready_in;
   logic [OW-1:0]          rsp_data_ff, rsp_data_in;

   function automatic logic [PB-1:0] eff_period(input logic [7:0] v);
      logic [PB-1:0] r;
      if (v == 8'd0)                 r = PB'(1);
      else if (int'(v) > PERIOD_MAX) r = PB'(PERIOD_MAX);
      else                           r = PB'(v);
      return r;
   endfunction

   // drop guard bits rounding to nearest, ties away from zero, then saturate
   function automatic logic signed [P:0] round_sat(input logic signed [AW:0] v);
      logic [AW:0] m;
      logic [AW:0] q;
      logic [P:0]  r;
      m = v[AW] ? (AW+1)'(-v) : (AW+1)'(v);
      q = (m + ((AW+1)'(1) << (G - 1))) >> G;
      if (q > (AW+1)'({P{1'b1}})) r = {1'b0, {P{1'b1}}};
      else                        r = q[P:0];
      return v[AW] ? -r : r;
   endfunction

   function automatic logic signed [P:0] sat_sub(input logic signed [P:0] a,
                                                 input logic signed [P:0] b);
      logic signed [P+1:0] d;
      logic signed [P+1:0] lim;
      logic signed [P:0]   r;
      d   = (P+2)'(a) - (P+2)'(b);
      lim = (P+2)'({P{1'b1}});
      if (d > lim)       r = (P+1)'(lim);
      else if (d < -lim) r = (P+1)'(-lim);
      else               r = d[P:0];
      return r;
   endfunction

   logic [PB-1:0]        ps, pl, pg, p_cur;
   logic                 ready_now;
   logic signed [GW-1:0] cur_sum, sum_new;
   logic signed [AW-1:0] cur_avg;
   logic [PB+1:0]        rem_sh;
   logic [NS-1:0]        mag;
   logic signed [AW-1:0] q_signed;
   logic signed [P:0]    sig_out;

   always_comb begin
      ps        = eff_period(short_ff);
      pl        = eff_period(long_ff);
      pg        = eff_period(sigp_ff);
      ready_now = (int'(idx_ff) >= int'(pl)) && (int'(idx_ff) >= int'(pg));
      case (sel_ff)
         AVG_FAST: begin
            p_cur = ps; cur_sum = GW'(signed'({1'b0, fast_sum_ff})); cur_avg = fast_avg_ff;
         end
         AVG_SLOW: begin
            p_cur = pl; cur_sum = GW'(signed'({1'b0, slow_sum_ff})); cur_avg = slow_avg_ff;
         end
         default: begin
            p_cur = pg; cur_sum = sig_sum_ff; cur_avg = sig_avg_ff;
         end
      endcase
      sum_new  = cur_sum + GW'(x_ff);
      rem_sh   = {rem_ff[PB:0], num_ff[NS-1]};
      mag      = num_ff[NS-1] ? NS'(-num_ff) : NS'(num_ff);
      q_signed = neg_ff ? -AW'(num_ff) : AW'(num_ff);
      sig_out  = round_sat((AW+1)'(rs_ff));

      state_in        = state_ff;
      sel_in          = sel_ff;
      short_in        = short_ff;
      long_in         = long_ff;
      sigp_in         = sigp_ff;
      sample_index_in = sample_index_ff;
      idx_in          = idx_ff;
      fast_avg_in     = fast_avg_ff;
      slow_avg_in     = slow_avg_ff;
      sig_avg_in      = sig_avg_ff;
      fast_sum_in     = fast_sum_ff;
      slow_sum_in     = slow_sum_ff;
      sig_sum_in      = sig_sum_ff;
      price_in        = price_ff;
      x_in            = x_ff;
      dif_in          = dif_ff;
      num_in          = num_ff;
      mcand_in        = mcand_ff;
      mult_in         = mult_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      neg_in          = neg_ff;
      skip_in         = skip_ff;
      rf_in           = rf_ff;
      rs_in           = rs_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_ready_in    = rsp_ready_ff;
      rsp_data_in     = rsp_data_ff;
      req_tready      = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SHORT_PERIOD:  short_in = csr_wdata;
            CSR_LONG_PERIOD:   long_in  = csr_wdata;
            CSR_SIGNAL_PERIOD: sigp_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               price_in = req_tdata[P-1:0];
               x_in     = (P+1)'({1'b0, req_tdata[P-1:0]});
               sel_in   = AVG_FAST;
               idx_in   = sample_index_ff;
               if (req_tuser) begin
                  idx_in      = '0;
                  fast_avg_in = '0;
                  slow_avg_in = '0;
                  sig_avg_in  = '0;
                  fast_sum_in = '0;
                  slow_sum_in = '0;
                  sig_sum_in  = '0;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            skip_in = 1'b0;
            if (int'(idx_ff) + 1 <= int'(p_cur)) begin
               case (sel_ff)
                  AVG_FAST: fast_sum_in = SW'(sum_new);
                  AVG_SLOW: slow_sum_in = SW'(sum_new);
                  default:  sig_sum_in  = sum_new;
               endcase
            end
            if (int'(idx_ff) + 1 < int'(p_cur)) begin
               skip_in  = 1'b1;
               num_in   = '0;
               neg_in   = 1'b0;
               state_in = ST_STORE;
            end else if (int'(idx_ff) + 1 == int'(p_cur)) begin
               num_in   = NS'(sum_new) <<< G;
               den_in   = (PB+1)'(p_cur);
               state_in = ST_ROUND;
            end else begin
               num_in   = NS'(x_ff) <<< (G + 1);
               mcand_in = NS'(cur_avg);
               mult_in  = p_cur - PB'(1);
               den_in   = (PB+1)'(p_cur) + (PB+1)'(1);
               cnt_in   = CW'(PB);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add over the bits of p-1
            if (mult_ff[0]) num_in = num_ff + mcand_ff;
            mcand_in = mcand_ff <<< 1;
            mult_in  = mult_ff >> 1;
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            neg_in   = num_ff[NS-1];
            num_in   = mag + NS'(den_ff >> 1);
            rem_in   = '0;
            cnt_in   = CW'(NS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= (PB+2)'(den_ff)) begin
               rem_in = rem_sh - (PB+2)'(den_ff);
               num_in = {num_ff[NS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = ST_STORE;
         end
         ST_STORE: begin
            case (sel_ff)
               AVG_FAST: begin
                  if (!skip_ff) fast_avg_in = q_signed;
                  rf_in    = q_signed;
                  x_in     = (P+1)'({1'b0, price_ff});
                  sel_in   = AVG_SLOW;
                  state_in = ST_SETUP;
               end
               AVG_SLOW: begin
                  if (!skip_ff) slow_avg_in = q_signed;
                  rs_in    = q_signed;
                  state_in = ST_DIFF;
               end
               default: begin
                  if (!skip_ff) sig_avg_in = q_signed;
                  rs_in    = q_signed;
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_DIFF: begin
            if (int'(idx_ff) >= int'(pl))
               dif_in = round_sat((AW+1)'(rf_ff) - (AW+1)'(rs_ff));
            else
               dif_in = '0;
            x_in     = dif_in;
            sel_in   = AVG_SIGNAL;
            state_in = ST_SETUP;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ready_in = ready_now;
               rsp_data_in  = {(ready_now ? sat_sub(dif_ff, sig_out) : (P+1)'(0)),
                               sig_out, dif_ff};
               if (idx_ff < IDX_SAT) sample_index_in = idx_ff + IW'(1);
               else                  sample_index_in = idx_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         short_ff        <= SHORT_PERIOD_RESET;
         long_ff         <= LONG_PERIOD_RESET;
         sigp_ff         <= SIGNAL_PERIOD_RESET;
         sample_index_ff <= '0;
         fast_avg_ff     <= '0;
         slow_avg_ff     <= '0;
         sig_avg_ff      <= '0;
         fast_sum_ff     <= '0;
         slow_sum_ff     <= '0;
         sig_sum_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         short_ff        <= short_in;
         long_ff         <= long_in;
         sigp_ff         <= sigp_in;
         sample_index_ff <= sample_index_in;
         fast_avg_ff     <= fast_avg_in;
         slow_avg_ff     <= slow_avg_in;
         sig_avg_ff      <= sig_avg_in;
         fast_sum_ff     <= fast_sum_in;
         slow_sum_ff     <= slow_sum_in;
         sig_sum_ff      <= sig_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      sel_ff       <= sel_in;
      idx_ff       <= idx_in;
      price_ff     <= price_in;
      x_ff         <= x_in;
      dif_ff       <= dif_in;
      num_ff       <= num_in;
      mcand_ff     <= mcand_in;
      mult_ff      <= mult_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      skip_ff      <= skip_in;
      rf_ff        <= rf_in;
      rs_ff        <= rs_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ready_ff;
   assign rsp_tdata  = OUT_DW'(rsp_data_ff);

   // a request moves the sequencer out of idle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SETUP))
      else $error("request not started");

   // divider never runs on a zero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("zero divisor");

   // oscillator stays zero while warming up
   a_osc_warmup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready_ff) |-> (rsp_data_ff[OW-1:2*(P+1)] == '0))
      else $error("oscillator during warm-up");

   // sample index never passes its saturation point
   a_index_sat: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= IDX_SAT)
      else $error("sample index overflow");

endmodule
